### src/tick_task_scheduler_table_defines.svh
// Assertion macros shared by the scheduler table RTL.
`ifndef TICK_TASK_SCHEDULER_TABLE_DEFINES_SVH
`define TICK_TASK_SCHEDULER_TABLE_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Checks that a consequence holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a consequence holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tts_pkg.sv
// Types, constants and helpers of the task scheduler table.
`default_nettype none

package tts_pkg;

    localparam int SLOT_COUNT  = 8;
    localparam int MAX_RESULTS = 8;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam logic [7:0] PEND_MAX = 8'hFF;

    typedef enum logic [1:0] {
        ACT_ADD      = 2'd0,
        ACT_DELETE   = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_DISPATCH = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_DELETED  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_RUN      = 3'd4,
        ST_NONE_DUE = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_NONE
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [7:0]  task_tag;
        logic [15:0] first_delay;
        logic [15:0] repeat_period;
        logic [2:0]  slot_index;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic [2:0] slot;
        logic [7:0] run_tag;
        logic       last;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic single;
        logic step;
        logic none;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    can_emit;
        logic    hit;
        logic    ptr_last;
        logic    emitted;
    } t_dp_stat;

    function automatic logic [2:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+2:0] wide;
        wide = {3'b000, idx};
        return wide[2:0];
    endfunction

    function automatic logic [SLOT_W-1:0] field_slot(input logic [2:0] idx);
        logic [SLOT_W+2:0] wide;
        wide = {SLOT_W'(0), idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### src/tts_if.sv
// Request and response channel interfaces of the task scheduler table.
`default_nettype none

interface tts_req_if import tts_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface tts_rsp_if import tts_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

### src/tts_dpath.sv
// Datapath of the task scheduler table: slot storage, scan pointer and result register.
`default_nettype none
`include "tick_task_scheduler_table_defines.svh"

module tts_dpath import tts_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_req     i_item,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_stat      o_stat,
    tts_rsp_if.source     o_rsp
);

    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [SLOT_COUNT-1:0] r_due, n_due;
    logic [7:0]            r_tag    [SLOT_COUNT];
    logic [15:0]           r_delay  [SLOT_COUNT];
    logic [15:0]           r_period [SLOT_COUNT];
    logic [7:0]            r_pend   [SLOT_COUNT];
    logic [SLOT_W-1:0]     r_ptr, n_ptr;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;
    t_req                  r_item;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_idx;
    logic [7:0]        wr_tag;
    logic [15:0]       wr_delay;
    logic [15:0]       wr_period;
    logic [7:0]        wr_pend;

    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] del_idx;
    logic              del_oob;
    logic [7:0]        cur_tag;
    logic [15:0]       cur_delay;
    logic [15:0]       cur_period;
    logic [7:0]        cur_pend;
    logic              can_emit;
    logic              hit;
    logic              due_above;
    logic              emit;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(j);
            end
        end
        due_above = 1'b0;
        for (int j = 0; j < SLOT_COUNT; j++) begin
            if (j > int'(r_ptr) && r_due[j]) begin
                due_above = 1'b1;
            end
        end
    end

    assign del_idx    = field_slot(r_item.slot_index);
    assign del_oob    = 32'(r_item.slot_index) >= SLOT_COUNT;
    assign cur_tag    = r_tag[r_ptr];
    assign cur_delay  = r_delay[r_ptr];
    assign cur_period = r_period[r_ptr];
    assign cur_pend   = r_pend[r_ptr];
    assign can_emit   = !r_out_valid || o_rsp.ready;
    assign hit        = r_due[r_ptr] && (r_count < CNT_W'(MAX_RESULTS));

    always_comb begin
        n_valid     = r_valid;
        n_due       = r_due;
        n_ptr       = r_ptr;
        n_count     = r_count;
        n_out       = r_out;
        emit        = 1'b0;
        wr_en       = 1'b0;
        wr_idx      = r_ptr;
        wr_tag      = cur_tag;
        wr_delay    = cur_delay;
        wr_period   = cur_period;
        wr_pend     = cur_pend;

        if (i_cmd.load) begin
            n_ptr   = '0;
            n_count = '0;
        end

        if (i_cmd.single) begin
            emit = 1'b1;
            if (r_item.action == ACT_ADD) begin
                if (free_found) begin
                    wr_en             = 1'b1;
                    wr_idx            = free_idx;
                    wr_tag            = r_item.task_tag;
                    wr_delay          = r_item.first_delay;
                    wr_period         = r_item.repeat_period;
                    wr_pend           = 8'd0;
                    n_valid[free_idx] = 1'b1;
                    n_due[free_idx]   = 1'b0;
                    n_out = '{status: ST_ADDED, slot: slot_field(free_idx),
                              run_tag: 8'd0, last: 1'b1};
                end else begin
                    n_out = '{status: ST_FULL, slot: 3'd0, run_tag: 8'd0, last: 1'b1};
                end
            end else begin
                if (del_oob) begin
                    n_out = '{status: ST_EMPTY, slot: r_item.slot_index,
                              run_tag: 8'd0, last: 1'b1};
                end else begin
                    n_out = '{status: r_valid[del_idx] ? ST_DELETED : ST_EMPTY,
                              slot: r_item.slot_index, run_tag: 8'd0, last: 1'b1};
                    n_valid[del_idx] = 1'b0;
                    n_due[del_idx]   = 1'b0;
                end
            end
        end

        if (i_cmd.step) begin
            n_ptr = r_ptr + SLOT_W'(1);
            if (r_item.action == ACT_TICK) begin
                if (r_valid[r_ptr]) begin
                    wr_en = 1'b1;
                    if (cur_delay == 16'd0) begin
                        wr_pend      = (cur_pend == PEND_MAX) ? cur_pend : cur_pend + 8'd1;
                        n_due[r_ptr] = 1'b1;
                        if (cur_period != 16'd0) begin
                            wr_delay = cur_period;
                        end
                    end else begin
                        wr_delay = cur_delay - 16'd1;
                    end
                end
            end else if (hit) begin
                emit    = 1'b1;
                wr_en   = 1'b1;
                wr_pend = cur_pend - 8'd1;
                n_count = r_count + CNT_W'(1);
                if (cur_period == 16'd0) begin
                    n_valid[r_ptr] = 1'b0;
                    n_due[r_ptr]   = 1'b0;
                end else begin
                    n_due[r_ptr] = (cur_pend != 8'd1);
                end
                n_out = '{status: ST_RUN, slot: slot_field(r_ptr), run_tag: cur_tag,
                          last: (r_count == CNT_W'(MAX_RESULTS - 1)) || !due_above};
            end
        end

        if (i_cmd.none) begin
            emit  = 1'b1;
            n_out = '{status: ST_NONE_DUE, slot: 3'd0, run_tag: 8'd0, last: 1'b1};
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_due       <= '0;
            r_ptr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_due       <= n_due;
            r_ptr       <= n_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tag[wr_idx]    <= wr_tag;
            r_delay[wr_idx]  <= wr_delay;
            r_period[wr_idx] <= wr_period;
            r_pend[wr_idx]   <= wr_pend;
        end
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        r_out <= n_out;
    end

    assign o_stat = '{action: r_item.action, can_emit: can_emit, hit: hit,
                      ptr_last: (r_ptr == SLOT_W'(SLOT_COUNT - 1)),
                      emitted: (r_count != '0)};

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    `ASSERT_ALWAYS(a_due_valid, i_clk, i_rst_n, (r_due & ~r_valid) == '0,
        "A slot is marked due while it is not valid.")
    `ASSERT_IMPLIES(a_emit_room, i_clk, i_rst_n, emit, can_emit,
        "A result was written while the result register still held an untaken transfer.")
    `ASSERT_IMPLIES(a_one_cmd, i_clk, i_rst_n, 1'b1,
        $onehot0({i_cmd.load, i_cmd.single, i_cmd.step, i_cmd.none}),
        "More than one datapath command is active in a cycle.")

endmodule

`default_nettype wire

### src/tts_ctrl.sv
// Controller state machine of the task scheduler table.
`default_nettype none
`include "tick_task_scheduler_table_defines.svh"

module tts_ctrl import tts_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.action) inside
                    ACT_ADD, ACT_DELETE: begin
                        if (i_stat.can_emit) begin
                            o_cmd.single = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_SCAN;
                    end
                endcase
            end
            S_SCAN: begin
                // A due slot waits here until the result register has room.
                if (!(i_stat.action == ACT_DISPATCH && i_stat.hit && !i_stat.can_emit)) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.ptr_last) begin
                        if (i_stat.action == ACT_DISPATCH && !i_stat.emitted && !i_stat.hit) begin
                            n_state = S_NONE;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_NONE: begin
                if (i_stat.can_emit) begin
                    o_cmd.none = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_valid && o_ready, r_state == S_EXEC,
        "An accepted transfer did not start execution.")
    `ASSERT_IMPLIES(a_none_empty, i_clk, i_rst_n, r_state == S_NONE,
        !i_stat.emitted && i_stat.action == ACT_DISPATCH,
        "The idle result is pending although a task was dispatched.")

endmodule

`default_nettype wire

### src/tick_task_scheduler_table.sv
// Top level of the tick-driven task scheduler table.
//
//  channel  direction  payload                                                   handshake
//  i_req    in         action, task_tag, first_delay, repeat_period, slot_index  valid/ready
//  o_rsp    out        status, slot, run_tag, last                               valid/ready
//
// Add and delete load their result after the transfer, once the result register is free.
// Tick and dispatch walk the slot table one slot per cycle through the shared
// slot read port; a dispatch that finds no task due then reports none due.
// Reset clears the valid and due bits of every slot; there is no clearing pass.
// A due slot holds the scan while the result register still waits to be taken.
// A new request is taken once the previous one is finished, even while its last
// result still waits in the result register.
`default_nettype none

module tick_task_scheduler_table import tts_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tts_req_if.sink   i_req,
    tts_rsp_if.source o_rsp
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     ctrl_ready;

    tts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (ctrl_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    tts_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_req.data),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_rsp   (o_rsp)
    );

    assign i_req.ready = ctrl_ready;

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench of the tick-driven task scheduler table.
module tb;
    import tts_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 3 * SLOT_COUNT + 10;

    typedef struct {
        t_req  req;
        bit    typed;
        t_rsp  known;
    } t_sched_row;

    logic i_clk;
    logic i_rst_n;

    tts_req_if req_ch();
    tts_rsp_if rsp_ch();

    tick_task_scheduler_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic        tbl_valid  [SLOT_COUNT];
    logic [7:0]  tbl_tag    [SLOT_COUNT];
    logic [15:0] tbl_delay  [SLOT_COUNT];
    logic [15:0] tbl_period [SLOT_COUNT];
    logic [7:0]  tbl_runs   [SLOT_COUNT];

    t_rsp       report_q[$];
    t_sched_row directed_rows[$];
    int         mismatch_cnt = 0;
    int         idle_cycles = 0;
    int         rsp_stall = 0;
    bit         send_calm = 0;
    bit         rsp_calm = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_entry(input int i);
        tbl_valid[i] = 1'b0;
        tbl_tag[i] = '0;
        tbl_delay[i] = '0;
        tbl_period[i] = '0;
        tbl_runs[i] = '0;
    endfunction

    function automatic void post_report(input t_status st, input logic [2:0] sl,
                                        input logic [7:0] tag);
        t_rsp r;
        r.status = st;
        r.slot = sl;
        r.run_tag = tag;
        r.last = 1'b0;
        report_q.push_back(r);
    endfunction

    // Updates the scheduler image for one accepted request and queues its reports.
    function automatic void apply_action(input t_req r);
        int free_i;
        int n;
        free_i = -1;
        n = 0;
        case (r.action)
            ACT_ADD: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!tbl_valid[i] && free_i < 0) free_i = i;
                end
                if (free_i < 0) begin
                    post_report(ST_FULL, 3'd0, 8'd0);
                end else begin
                    tbl_valid[free_i] = 1'b1;
                    tbl_tag[free_i] = r.task_tag;
                    tbl_delay[free_i] = r.first_delay;
                    tbl_period[free_i] = r.repeat_period;
                    tbl_runs[free_i] = '0;
                    post_report(ST_ADDED, 3'(free_i), 8'd0);
                end
            end
            ACT_DELETE: begin
                if (int'(r.slot_index) >= SLOT_COUNT) begin
                    post_report(ST_EMPTY, r.slot_index, 8'd0);
                end else begin
                    post_report(tbl_valid[r.slot_index] ? ST_DELETED : ST_EMPTY,
                                r.slot_index, 8'd0);
                    clear_entry(int'(r.slot_index));
                end
            end
            ACT_TICK: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_delay[i] == 16'd0) begin
                            if (tbl_runs[i] != PEND_MAX) tbl_runs[i] = tbl_runs[i] + 8'd1;
                            if (tbl_period[i] != 16'd0) tbl_delay[i] = tbl_period[i];
                        end else begin
                            tbl_delay[i] = tbl_delay[i] - 16'd1;
                        end
                    end
                end
            end
            default: begin
                for (int i = 0; i < SLOT_COUNT && n < MAX_RESULTS; i++) begin
                    if (tbl_valid[i] && tbl_runs[i] != 8'd0) begin
                        post_report(ST_RUN, 3'(i), tbl_tag[i]);
                        n++;
                        tbl_runs[i] = tbl_runs[i] - 8'd1;
                        if (tbl_period[i] == 16'd0) clear_entry(i);
                    end
                end
                if (n == 0) post_report(ST_NONE_DUE, 3'd0, 8'd0);
            end
        endcase
        if (r.action != ACT_TICK) report_q[report_q.size() - 1].last = 1'b1;
    endfunction

    function automatic t_req mk_req(input t_action a, input logic [7:0] tag,
                                    input logic [15:0] dly, input logic [15:0] per,
                                    input logic [2:0] idx);
        t_req r;
        r.action = a;
        r.task_tag = tag;
        r.first_delay = dly;
        r.repeat_period = per;
        r.slot_index = idx;
        return r;
    endfunction

    function automatic t_sched_row mk_row(input t_action a, input logic [7:0] tag,
                                          input logic [15:0] dly, input logic [15:0] per,
                                          input logic [2:0] idx, input bit typed,
                                          input t_status st, input logic [2:0] sl);
        t_sched_row row;
        row.req = mk_req(a, tag, dly, per, idx);
        row.typed = typed;
        row.known.status = st;
        row.known.slot = sl;
        row.known.run_tag = 8'd0;
        row.known.last = 1'b1;
        return row;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) r.action = ACT_TICK;
        else if (pick < 60) r.action = ACT_DISPATCH;
        else if (pick < 85) r.action = ACT_ADD;
        else r.action = ACT_DELETE;
        r.task_tag = 8'($urandom);
        pick = $urandom_range(0, 9);
        r.first_delay = (pick < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 8) r.repeat_period = 16'd0;
        else if (pick < 17) r.repeat_period = 16'($urandom_range(1, 4));
        else r.repeat_period = 16'($urandom);
        r.slot_index = 3'($urandom_range(0, 7));
        return r;
    endfunction

    task automatic drive_req(input t_req r, input bit typed, input t_rsp known);
        int gap;
        int n0;
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        n0 = report_q.size();
        apply_action(r);
        if (typed) report_q[n0] = known;
    endtask

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    function automatic void check_report(input t_rsp got);
        t_rsp want;
        if (report_q.size() == 0) begin
            $display("%0t: no result expected, actual status %0d slot %0d tag %0d last %0d",
                     $time, got.status, got.slot, got.run_tag, got.last);
            mismatch_cnt++;
        end else begin
            want = report_q.pop_front();
            compare_field("status", int'(want.status), int'(got.status));
            compare_field("slot", int'(want.slot), int'(got.slot));
            compare_field("run_tag", int'(want.run_tag), int'(got.run_tag));
            compare_field("last", int'(want.last), int'(got.last));
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            check_report(rsp_ch.data);
            if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
            rsp_stall = rsp_calm ? 0 : $urandom_range(0, 9);
        end else if (rsp_stall > 0) begin
            rsp_stall--;
        end
        rsp_ch.ready <= (rsp_stall == 0);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            clear_entry(i);
        end

        directed_rows.push_back(mk_row(ACT_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0,
                                       1, ST_NONE_DUE, 3'd0));
        directed_rows.push_back(mk_row(ACT_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd3,
                                       1, ST_EMPTY, 3'd3));
        directed_rows.push_back(mk_row(ACT_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7,
                                       0, ST_ADDED, 3'd0));
        directed_rows.push_back(mk_row(ACT_ADD, 8'h00, 16'h0000, 16'h0000, 3'd7,
                                       1, ST_ADDED, 3'd0));
        directed_rows.push_back(mk_row(ACT_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd0,
                                       1, ST_ADDED, 3'd1));
        directed_rows.push_back(mk_row(ACT_ADD, 8'hA5, 16'h0000, 16'h0001, 3'd5,
                                       1, ST_ADDED, 3'd2));
        directed_rows.push_back(mk_row(ACT_ADD, 8'h5A, 16'h0001, 16'h0000, 3'd2,
                                       1, ST_ADDED, 3'd3));
        directed_rows.push_back(mk_row(ACT_ADD, 8'h01, 16'h0000, 16'hFFFF, 3'd1,
                                       1, ST_ADDED, 3'd4));
        directed_rows.push_back(mk_row(ACT_ADD, 8'h80, 16'h0002, 16'h0003, 3'd6,
                                       1, ST_ADDED, 3'd5));
        directed_rows.push_back(mk_row(ACT_ADD, 8'h7F, 16'hFFFF, 16'h0000, 3'd4,
                                       1, ST_ADDED, 3'd6));
        directed_rows.push_back(mk_row(ACT_ADD, 8'h3C, 16'h0000, 16'h0002, 3'd3,
                                       1, ST_ADDED, 3'd7));
        directed_rows.push_back(mk_row(ACT_ADD, 8'hC3, 16'h0001, 16'h0001, 3'd0,
                                       1, ST_FULL, 3'd0));
        directed_rows.push_back(mk_row(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0,
                                       0, ST_ADDED, 3'd0));
        directed_rows.push_back(mk_row(ACT_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0,
                                       0, ST_ADDED, 3'd0));
        directed_rows.push_back(mk_row(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0,
                                       0, ST_ADDED, 3'd0));
        directed_rows.push_back(mk_row(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0,
                                       0, ST_ADDED, 3'd0));
        directed_rows.push_back(mk_row(ACT_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0,
                                       0, ST_ADDED, 3'd0));
        directed_rows.push_back(mk_row(ACT_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd7,
                                       1, ST_DELETED, 3'd7));
        directed_rows.push_back(mk_row(ACT_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd7,
                                       1, ST_EMPTY, 3'd7));
        directed_rows.push_back(mk_row(ACT_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0,
                                       0, ST_ADDED, 3'd0));
        directed_rows.push_back(mk_row(ACT_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd0,
                                       0, ST_ADDED, 3'd0));
        directed_rows.push_back(mk_row(ACT_ADD, 8'h42, 16'h0003, 16'h0001, 3'd0,
                                       0, ST_ADDED, 3'd0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            drive_req(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].known);
        end

        repeat (100) drive_req(random_req(), 0, '0);

        // Drain everything, then saturate a one-shot task's run count with a long tick burst.
        req_ch.valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        drive_req(mk_req(ACT_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd0), 0, '0);
        drive_req(mk_req(ACT_ADD, 8'h99, 16'h0000, 16'h0000, 3'd0), 0, '0);
        repeat (260) begin
            drive_req(mk_req(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0), 0, '0);
        end
        repeat (2) begin
            drive_req(mk_req(ACT_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0), 0, '0);
        end

        repeat (76) drive_req(random_req(), 0, '0);

        req_ch.valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
